/* sv/jac_pkg.sv */
package jac_pkg;

    localparam int WINDOW_DEPTH   = 16;
    localparam int WARMUP_SAMPLES = 50;
    localparam int SAMPLE_BITS    = 12;

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = $clog2(WINDOW_DEPTH * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int ACC_W  = $clog2(WARMUP_SAMPLES * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int CNT_W  = $clog2(WARMUP_SAMPLES + 1);
    localparam int RING_W = 2 * SAMPLE_BITS;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_DATA_W-1:0] CLICK_MIN_RESET = 16'd50;
    localparam logic [CFG_DATA_W-1:0] CLICK_MAX_RESET = 16'd500;

    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // reciprocal constants for exact truncating division
    localparam int WS   = ACC_W + $clog2(WARMUP_SAMPLES);
    localparam int WM_W = ACC_W + 1;
    localparam logic [63:0] WM = ((64'd1 << WS) + 64'(WARMUP_SAMPLES) - 64'd1)
                                 / 64'(WARMUP_SAMPLES);
    localparam int DS   = SUM_W + $clog2(WINDOW_DEPTH);
    localparam int DM_W = SUM_W + 1;
    localparam logic [63:0] DM = ((64'd1 << DS) + 64'(WINDOW_DEPTH) - 64'd1)
                                 / 64'(WINDOW_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLICK_MIN = 1'b0,
        CFG_CLICK_MAX = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_x;
        logic [SAMPLE_BITS-1:0] sample_y;
        logic                   button_level;
        logic [31:0]            time_ms;
    } t_sample;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mean_x;
        logic [SAMPLE_BITS-1:0] mean_y;
        logic                   pressed;
        logic                   click_trigger;
    } t_result;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] click_min_ms;
        logic [CFG_DATA_W-1:0] click_max_ms;
    } t_cfg;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

    function automatic logic [SAMPLE_BITS-1:0] warmup_mean(input logic [ACC_W-1:0] acc);
        logic [ACC_W+WM_W-1:0] prod;
        prod = {{WM_W{1'b0}}, acc} * {{ACC_W{1'b0}}, WM_W'(WM)};
        return SAMPLE_BITS'(prod >> WS);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] window_mean(input logic [SUM_W-1:0] sum);
        logic [SUM_W+DM_W-1:0] prod;
        prod = {{DM_W{1'b0}}, sum} * {{SUM_W{1'b0}}, DM_W'(DM)};
        return SAMPLE_BITS'(prod >> DS);
    endfunction

endpackage

/* sv/jac_if.sv */
interface jac_in_if;
    logic             valid;
    logic             ready;
    jac_pkg::t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jac_out_if;
    logic             valid;
    logic             ready;
    jac_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/joystick_average_and_click_top.sv */
// a result is offered once its sample has passed stage 1, stage 2 and the result FIFO
// throughput: one sample per cycle while the result FIFO has room, set by the ring read-modify-write path
// one ready-low cycle follows the last preload sample while the mean is loaded
// preload samples give no result; ring entries not yet rewritten read as preload mean
// reset: synchronous, active low; no clearing pass, ready in the first cycle after reset
module joystick_average_and_click_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [jac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    jac_in_if.sink                          i_in,
    jac_out_if.source                       o_out
);

    jac_pkg::t_cfg              r_cfg;
    jac_pkg::t_push             w_push;
    logic [jac_pkg::FCNT_W-1:0] w_fifo_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.click_min_ms <= jac_pkg::CLICK_MIN_RESET;
            r_cfg.click_max_ms <= jac_pkg::CLICK_MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (jac_pkg::t_cfg_idx'(i_cfg_idx))
                jac_pkg::CFG_CLICK_MIN: r_cfg.click_min_ms <= i_cfg_data;
                jac_pkg::CFG_CLICK_MAX: r_cfg.click_max_ms <= i_cfg_data;
            endcase
        end
    end

    jac_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_fifo_count (w_fifo_count),
        .i_in         (i_in),
        .o_push       (w_push)
    );

    jac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_count (w_fifo_count),
        .o_out   (o_out)
    );

endmodule

/* sv/jac_ram.sv */
module jac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/jac_filter.sv */
module jac_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jac_pkg::t_cfg               i_cfg,
    input  logic [jac_pkg::FCNT_W-1:0]  i_fifo_count,
    jac_in_if.sink                      i_in,
    output jac_pkg::t_push              o_push
);

    // preload
    logic [jac_pkg::CNT_W-1:0]       r_wcnt;
    logic [jac_pkg::ACC_W-1:0]       r_acc_x;
    logic [jac_pkg::ACC_W-1:0]       r_acc_y;
    logic                            r_ph1;
    logic                            r_ph2;
    logic [jac_pkg::SAMPLE_BITS-1:0] r_mean_x;
    logic [jac_pkg::SAMPLE_BITS-1:0] r_mean_y;

    // ring control and window sums
    logic [jac_pkg::SLOT_W-1:0]      r_slot;
    logic                            r_wrapped;
    logic [jac_pkg::SUM_W-1:0]       r_sum_x;
    logic [jac_pkg::SUM_W-1:0]       r_sum_y;

    // button
    logic                            r_prev;
    logic [31:0]                     r_last;

    // stage 1
    logic                            r_s1_v;
    jac_pkg::t_sample                r_s1_smp;
    logic [jac_pkg::SLOT_W-1:0]      r_s1_slot;
    logic                            r_s1_old_ok;

    // stage 2
    logic                            r_s2_v;
    logic [jac_pkg::SUM_W-1:0]       r_s2_sum_x;
    logic [jac_pkg::SUM_W-1:0]       r_s2_sum_y;
    logic                            r_s2_pressed;
    logic                            r_s2_fall;
    logic [31:0]                     r_s2_dt;

    logic                            w_ready;
    logic                            w_accept;
    logic                            w_warm_done;
    logic [jac_pkg::FCNT_W:0]        w_inflight;
    logic [jac_pkg::RING_W-1:0]      w_rdata;
    logic [jac_pkg::SAMPLE_BITS-1:0] w_old_x;
    logic [jac_pkg::SAMPLE_BITS-1:0] w_old_y;
    logic [jac_pkg::SUM_W-1:0]       n_sum_x;
    logic [jac_pkg::SUM_W-1:0]       n_sum_y;
    logic                            w_fall;
    logic [31:0]                     n_dt;

    assign w_warm_done = (r_wcnt == jac_pkg::CNT_W'(jac_pkg::WARMUP_SAMPLES));
    assign w_inflight  = {1'b0, i_fifo_count} + (jac_pkg::FCNT_W + 1)'(r_s1_v)
                       + (jac_pkg::FCNT_W + 1)'(r_s2_v);
    assign w_ready     = !r_ph1
                       && (w_inflight < (jac_pkg::FCNT_W + 1)'(jac_pkg::FIFO_DEPTH));
    assign i_in.ready  = w_ready;
    assign w_accept    = i_in.valid && w_ready;

    jac_ram #(
        .WIDTH (jac_pkg::RING_W),
        .DEPTH (jac_pkg::WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_slot),
        .i_wdata ({r_s1_smp.sample_x, r_s1_smp.sample_y}),
        .i_re    (w_accept),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    // entries not yet rewritten since preload hold the preload mean
    always_comb begin
        if (r_s1_old_ok) begin
            w_old_x = w_rdata[jac_pkg::RING_W-1:jac_pkg::SAMPLE_BITS];
            w_old_y = w_rdata[jac_pkg::SAMPLE_BITS-1:0];
        end else begin
            w_old_x = r_mean_x;
            w_old_y = r_mean_y;
        end
    end

    assign n_sum_x = r_sum_x - jac_pkg::SUM_W'(w_old_x) + jac_pkg::SUM_W'(r_s1_smp.sample_x);
    assign n_sum_y = r_sum_y - jac_pkg::SUM_W'(w_old_y) + jac_pkg::SUM_W'(r_s1_smp.sample_y);
    assign w_fall  = r_prev && !r_s1_smp.button_level;
    assign n_dt    = r_s1_smp.time_ms - r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt    <= '0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_ph1     <= 1'b0;
            r_ph2     <= 1'b0;
            r_slot    <= '0;
            r_wrapped <= 1'b0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_prev    <= 1'b1;
            r_last    <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
        end else begin
            r_ph1  <= w_accept && !w_warm_done
                   && (r_wcnt == jac_pkg::CNT_W'(jac_pkg::WARMUP_SAMPLES - 1));
            r_ph2  <= r_ph1;
            r_s1_v <= w_accept && w_warm_done;
            r_s2_v <= r_s1_v;

            if (w_accept && !w_warm_done) begin
                r_wcnt  <= r_wcnt + jac_pkg::CNT_W'(1);
                r_acc_x <= r_acc_x + jac_pkg::ACC_W'(i_in.data.sample_x);
                r_acc_y <= r_acc_y + jac_pkg::ACC_W'(i_in.data.sample_y);
            end

            if (w_accept && w_warm_done) begin
                if (r_slot == jac_pkg::SLOT_W'(jac_pkg::WINDOW_DEPTH - 1)) begin
                    r_slot    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_slot <= r_slot + jac_pkg::SLOT_W'(1);
                end
            end

            if (r_ph2) begin
                r_sum_x <= jac_pkg::SUM_W'(r_mean_x) * jac_pkg::SUM_W'(jac_pkg::WINDOW_DEPTH);
                r_sum_y <= jac_pkg::SUM_W'(r_mean_y) * jac_pkg::SUM_W'(jac_pkg::WINDOW_DEPTH);
            end else if (r_s1_v) begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
            end

            if (r_s1_v) begin
                r_prev <= r_s1_smp.button_level;
                if (w_fall) begin
                    r_last <= r_s1_smp.time_ms;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph1) begin
            r_mean_x <= jac_pkg::warmup_mean(r_acc_x);
            r_mean_y <= jac_pkg::warmup_mean(r_acc_y);
        end
        if (w_accept) begin
            r_s1_smp    <= i_in.data;
            r_s1_slot   <= r_slot;
            r_s1_old_ok <= r_wrapped;
        end
        r_s2_sum_x   <= n_sum_x;
        r_s2_sum_y   <= n_sum_y;
        r_s2_pressed <= !r_s1_smp.button_level;
        r_s2_fall    <= w_fall;
        r_s2_dt      <= n_dt;
    end

    always_comb begin
        o_push.valid              = r_s2_v;
        o_push.data.mean_x        = jac_pkg::window_mean(r_s2_sum_x);
        o_push.data.mean_y        = jac_pkg::window_mean(r_s2_sum_y);
        o_push.data.pressed       = r_s2_pressed;
        o_push.data.click_trigger = r_s2_fall
                                  && (r_s2_dt < {16'd0, i_cfg.click_max_ms})
                                  && (r_s2_dt > {16'd0, i_cfg.click_min_ms});
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inflight <= (jac_pkg::FCNT_W + 1)'(jac_pkg::FIFO_DEPTH))
        else $error("result slots overrun");

    a_sum_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph2 |-> !r_s1_v)
        else $error("filtered sample before window sum load");

    a_ph1_after_preload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph1 |-> w_warm_done && !w_ready)
        else $error("preload end without full count");

    a_wrap_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_wrapped) |-> (r_slot == '0))
        else $error("ring wrap flag out of step with slot");

endmodule

/* sv/jac_fifo.sv */
module jac_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jac_pkg::t_push              i_push,
    output logic [jac_pkg::FCNT_W-1:0]  o_count,
    jac_out_if.source                   o_out
);

    jac_pkg::t_result              r_mem [jac_pkg::FIFO_DEPTH];
    logic [jac_pkg::FP_W-1:0]      r_wr;
    logic [jac_pkg::FP_W-1:0]      r_rd;
    logic [jac_pkg::FCNT_W-1:0]    r_count;
    logic                          w_pop;

    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_mem[r_rd];
    assign w_pop       = o_out.valid && o_out.ready;
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == jac_pkg::FP_W'(jac_pkg::FIFO_DEPTH - 1))
                      ? '0 : r_wr + jac_pkg::FP_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == jac_pkg::FP_W'(jac_pkg::FIFO_DEPTH - 1))
                      ? '0 : r_rd + jac_pkg::FP_W'(1);
            end
            unique case ({i_push.valid, w_pop})
                2'b10:   r_count <= r_count + jac_pkg::FCNT_W'(1);
                2'b01:   r_count <= r_count - jac_pkg::FCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

endmodule
